@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define HF2U_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define HF2U_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/hf2u_pkg.sv @@
package hf2u_pkg;

  // Binary16 layout.
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned MANT_W  = 10;
  localparam int unsigned EXP_W   = 5;
  localparam int unsigned SIG_W   = MANT_W + 1;

  // Datapath widths.
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned DEPTH_W = 5;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned PROD_W  = SIG_W + LEVEL_W;

  // Pixel packing.
  localparam int unsigned NUM_CHAN = 4;
  localparam int unsigned PIX_W    = NUM_CHAN * HALF_W;

  // Exponent codes and shift amounts.
  localparam logic [EXP_W-1:0]   EXP_ALL_ONES  = 5'h1F;
  localparam logic [EXP_W-1:0]   EXP_ZERO      = 5'h00;
  localparam logic [EXP_W-1:0]   EXP_UNITY     = 5'd15;
  localparam logic [SHIFT_W-1:0] SHIFT_BIAS    = 5'd25;
  localparam logic [SHIFT_W-1:0] SUBNORM_SHIFT = 5'd24;

  // Bit depth limits and reset value.
  localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 5'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 5'd16;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd10;

  // What a decoded channel turns into.
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_FULL,
    KIND_SCALE
  } kind_t;

  // Full scale 2^depth - 1 with the depth held to 1..16.
  function automatic logic [LEVEL_W-1:0] full_scale(input logic [DEPTH_W-1:0] depth);
    logic [DEPTH_W-1:0] d;
    logic [LEVEL_W:0]   ones;
    d = depth;
    if (d < DEPTH_MIN) begin
      d = DEPTH_MIN;
    end
    if (d > DEPTH_MAX) begin
      d = DEPTH_MAX;
    end
    ones = (17'd1 << d) - 17'd1;
    return ones[LEVEL_W-1:0];
  endfunction

endpackage

@@ design/hf2u_chan.sv @@
`include "assert_macros.svh"

// One channel: decode, multiply by full scale, shift and select.
module hf2u_chan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [hf2u_pkg::LEVEL_W-1:0]  fs_i,
  input  logic [hf2u_pkg::HALF_W-1:0]   half_i,
  output logic [hf2u_pkg::LEVEL_W-1:0]  level_o
);
  import hf2u_pkg::*;

  logic               sign;
  logic [EXP_W-1:0]   expo;
  logic [MANT_W-1:0]  mant;

  kind_t              s1_kind_nxt, s1_kind_r;
  logic [SIG_W-1:0]   s1_sig_nxt, s1_sig_r;
  logic [SHIFT_W-1:0] s1_shift_nxt, s1_shift_r;

  kind_t              s2_kind_r;
  logic [PROD_W-1:0]  s2_prod_nxt, s2_prod_r;
  logic [SHIFT_W-1:0] s2_shift_r;

  logic [PROD_W-1:0]  shifted;
  logic [LEVEL_W-1:0] level_nxt, level_r;

  assign sign = half_i[HALF_W-1];
  assign expo = half_i[HALF_W-2 -: EXP_W];
  assign mant = half_i[MANT_W-1:0];

  // Stage 1: classify the word. Anything at or above 1.0 saturates, so only
  // values below one go through the multiplier, shifted right by 11 to 24.
  always_comb begin
    s1_kind_nxt  = KIND_SCALE;
    s1_sig_nxt   = {1'b1, mant};
    s1_shift_nxt = SHIFT_BIAS - expo;
    if (expo == EXP_ALL_ONES) begin
      s1_kind_nxt = (mant == '0 && !sign) ? KIND_FULL : KIND_ZERO;
    end else if (sign) begin
      s1_kind_nxt = KIND_ZERO;
    end else if (expo >= EXP_UNITY) begin
      s1_kind_nxt = KIND_FULL;
    end else if (expo == EXP_ZERO) begin
      s1_sig_nxt   = {1'b0, mant};
      s1_shift_nxt = SUBNORM_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r  <= s1_kind_nxt;
      s1_sig_r   <= s1_sig_nxt;
      s1_shift_r <= s1_shift_nxt;
    end
  end

  // Stage 2: exact product of significand and full scale.
  assign s2_prod_nxt = {{LEVEL_W{1'b0}}, s1_sig_r} * {{SIG_W{1'b0}}, fs_i};

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind_r  <= s1_kind_r;
      s2_prod_r  <= s2_prod_nxt;
      s2_shift_r <= s1_shift_r;
    end
  end

  // Stage 3: truncate toward zero; a value below one never reaches full scale.
  assign shifted = s2_prod_r >> s2_shift_r;

  always_comb begin
    case (s2_kind_r)
      KIND_FULL:  level_nxt = fs_i;
      KIND_SCALE: level_nxt = shifted[LEVEL_W-1:0];
      default:    level_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level_r <= level_nxt;
    end
  end

  assign level_o = level_r;

  `HF2U_ASSERT(a_full_lands, clk, rst_n, en && s2_kind_r == KIND_FULL |=> level_r == $past(fs_i), "saturated channel did not reach full scale")
  `HF2U_ASSERT(a_zero_lands, clk, rst_n, en && s2_kind_r == KIND_ZERO |=> level_r == '0, "zeroed channel did not give level zero")

endmodule

@@ design/hf2u_ctrl.sv @@
`include "assert_macros.svh"

// Valid bits of the three stages and the common advance enable.
module hf2u_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_ready,
  output logic in_ready,
  output logic out_valid,
  output logic en
);
  import hf2u_pkg::*;

  logic s1_vld_r, s2_vld_r, out_vld_r;

  // The pipe moves whenever the output register is empty or being taken.
  assign en        = !out_vld_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_valid;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  `HF2U_ASSERT(a_stall_holds, clk, rst_n, !en |=> $stable({s1_vld_r, s2_vld_r, out_vld_r}), "stage valid bits moved during a stall")
  `HF2U_ASSERT(a_out_from_s2, clk, rst_n, $rose(out_vld_r) |-> $past(s2_vld_r), "output became valid without an item in stage two")

endmodule

@@ design/half_float_to_unorm_rgba.sv @@
// Converts one RGBA pixel of four binary16 words per clock, unless the output
// stalls, into unsigned normalized levels of bit_depth bits (1 to 16;
// out-of-range depths are held to that span). Each channel is scaled by
// 2^bit_depth - 1 exactly and truncated toward zero; negatives, zeros and
// NaNs give 0, values at or above one and +infinity give full scale. The
// block takes one pixel every cycle while not stalled, through three register
// stages: decode, an 11 by 16 bit multiply per channel, then shift and select
// into the output register, where the result is presented. When the output
// register is full and not taken, in_tready drops in the same cycle. Write
// bit_depth only while no pixel is in flight.
module half_float_to_unorm_rgba (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration: bit_depth.
  input  logic                         cfg_wr_en,
  input  logic [hf2u_pkg::DEPTH_W-1:0] cfg_wr_data,
  // Input: red_half, green_half, blue_half, alpha_half from bit 0 up.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [hf2u_pkg::PIX_W-1:0]   in_tdata,
  // Output: red_level, green_level, blue_level, alpha_level from bit 0 up.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [hf2u_pkg::PIX_W-1:0]   out_tdata
);
  import hf2u_pkg::*;

  logic               en;
  logic [LEVEL_W-1:0] full_scale_r;

  // Full scale is worked out only at reset and when the depth is written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= full_scale(DEPTH_RESET);
    end else if (cfg_wr_en) begin
      full_scale_r <= full_scale(cfg_wr_data);
    end
  end

  hf2u_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .en        (en)
  );

  // One datapath per channel, all sharing the same enable.
  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_chan
    hf2u_chan u_chan (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .fs_i    (full_scale_r),
      .half_i  (in_tdata[ch*HALF_W +: HALF_W]),
      .level_o (out_tdata[ch*LEVEL_W +: LEVEL_W])
    );
  end

endmodule

@@ tb/unorm_pixel_monitor.sv @@
`timescale 1ns / 100ps

module unorm_pixel_monitor (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [hf2u_pkg::DEPTH_W-1:0] cfg_wr_data,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  // red_half, green_half, blue_half, alpha_half from bit 0 up.
  input  logic [hf2u_pkg::PIX_W-1:0]   in_tdata,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  // red_level, green_level, blue_level, alpha_level from bit 0 up.
  input  logic [hf2u_pkg::PIX_W-1:0]   out_tdata,
  output int unsigned                  mismatch_count,
  output int unsigned                  waiting_pixels
);

  // Red sits in the lowest bits, so it is declared last.
  typedef struct packed {
    logic [hf2u_pkg::LEVEL_W-1:0] alpha_level;
    logic [hf2u_pkg::LEVEL_W-1:0] blue_level;
    logic [hf2u_pkg::LEVEL_W-1:0] green_level;
    logic [hf2u_pkg::LEVEL_W-1:0] red_level;
  } rgba_levels_t;

  rgba_levels_t                 predicted_levels_q[$];
  rgba_levels_t                 got_pix;
  rgba_levels_t                 want_pix;
  logic [hf2u_pkg::DEPTH_W-1:0] depth_reg;
  logic [hf2u_pkg::LEVEL_W-1:0] scale;

  // Depths below one act as one and depths above sixteen as sixteen.
  function automatic logic [15:0] full_scale_of(input logic [4:0] depth);
    int unsigned eff;
    eff = depth;
    if (eff == 0) begin
      eff = 1;
    end else if (eff > 16) begin
      eff = 16;
    end
    return 16'hFFFF >> (16 - eff);
  endfunction

  // Exact scaling of one binary16 word, truncated toward zero and saturated.
  function automatic logic [15:0] half_to_level(input logic [15:0] h, input logic [15:0] fs);
    logic [4:0]  expo;
    logic [10:0] sig;
    logic [31:0] scaled;
    expo = h[14:10];
    if (expo == hf2u_pkg::EXP_ALL_ONES) begin
      // Only positive infinity survives; NaNs and negative infinity give zero.
      return (h[9:0] == 10'd0 && !h[15]) ? fs : 16'd0;
    end
    if (h[15]) begin
      return 16'd0;
    end
    sig = {expo != hf2u_pkg::EXP_ZERO, h[9:0]};
    scaled = 32'(sig) * 32'(fs);
    // Subnormals share the weight of the smallest normal exponent.
    if (expo == hf2u_pkg::EXP_ZERO) begin
      scaled = scaled >> 24;
    end else if (expo >= 25) begin
      scaled = scaled << (expo - 25);
    end else begin
      scaled = scaled >> (25 - expo);
    end
    if (scaled > fs) begin
      scaled = fs;
    end
    return scaled[15:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  // Outputs are checked before inputs are predicted; the pipeline has no
  // combinational path from input to output, so a pixel never leaves on the edge it enters.
  always @(posedge clk) begin
    if (!rst_n) begin
      depth_reg = hf2u_pkg::DEPTH_RESET;
      mismatch_count = 0;
      predicted_levels_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_pix = out_tdata;
        if (predicted_levels_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output item %h", out_tdata));
        end else begin
          want_pix = predicted_levels_q.pop_front();
          if (got_pix.red_level !== want_pix.red_level) begin
            report_mismatch($sformatf("red_level got %h, predicted %h",
                                      got_pix.red_level, want_pix.red_level));
          end
          if (got_pix.green_level !== want_pix.green_level) begin
            report_mismatch($sformatf("green_level got %h, predicted %h",
                                      got_pix.green_level, want_pix.green_level));
          end
          if (got_pix.blue_level !== want_pix.blue_level) begin
            report_mismatch($sformatf("blue_level got %h, predicted %h",
                                      got_pix.blue_level, want_pix.blue_level));
          end
          if (got_pix.alpha_level !== want_pix.alpha_level) begin
            report_mismatch($sformatf("alpha_level got %h, predicted %h",
                                      got_pix.alpha_level, want_pix.alpha_level));
          end
        end
      end
      if (cfg_wr_en) begin
        depth_reg = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        scale = full_scale_of(depth_reg);
        want_pix.red_level   = half_to_level(in_tdata[15:0], scale);
        want_pix.green_level = half_to_level(in_tdata[31:16], scale);
        want_pix.blue_level  = half_to_level(in_tdata[47:32], scale);
        want_pix.alpha_level = half_to_level(in_tdata[63:48], scale);
        predicted_levels_q.push_back(want_pix);
      end
    end
    waiting_pixels = predicted_levels_q.size();
  end

endmodule

@@ tb/tb_half_float_to_unorm_rgba.sv @@
`timescale 1ns / 100ps

module tb_half_float_to_unorm_rgba;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS = 150;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [hf2u_pkg::DEPTH_W-1:0] cfg_wr_data = '0;
  logic                         in_tvalid = 1'b0;
  wire                          in_tready;
  logic [hf2u_pkg::PIX_W-1:0]   in_tdata = '0;
  wire                          out_tvalid;
  logic                         out_tready = 1'b0;
  wire  [hf2u_pkg::PIX_W-1:0]   out_tdata;

  int unsigned mismatch_count;
  int unsigned waiting_pixels;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  // Zeros of both signs, one and its neighbors, the finite maximum,
  // infinities, NaNs, subnormal edges and a few ordinary fractions.
  logic [15:0] corner_halves[24] = '{
    16'h0000, 16'h8000, 16'h3C00, 16'h7BFF, 16'h7C00, 16'hFC00,
    16'h7E00, 16'hFE00, 16'h7C01, 16'h0001, 16'h03FF, 16'h0400,
    16'hBC00, 16'h3800, 16'h3BFF, 16'h3C01, 16'hFFFF, 16'h3555,
    16'h1400, 16'h0200, 16'h7FFF, 16'h5BFF, 16'h2E66, 16'h3A00
  };
  logic [4:0] phase_depths[10] = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd8,
                                   5'd12, 5'd2, 5'd16, 5'd1, 5'd5};

  half_float_to_unorm_rgba uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  unorm_pixel_monitor monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatch_count),
    .waiting_pixels(waiting_pixels)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_taken) begin
      hold_taken = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("half_float_to_unorm_rgba test failed");
      $finish;
    end
  end

  // Mostly values in the useful range below one, with the rest spread over
  // codes near one, large values, negatives and special encodings.
  function automatic logic [15:0] random_half();
    logic [15:0] special;
    case ($urandom_range(9))
      0, 1: return 16'($urandom);
      2, 3, 4, 5: return {1'b0, 5'($urandom_range(0, 14)), 10'($urandom)};
      6: return {1'b0, 5'($urandom_range(15, 16)), 10'($urandom_range(0, 3))};
      7: begin
        special = {1'($urandom_range(1)), hf2u_pkg::EXP_ALL_ONES, 10'd0};
        if ($urandom_range(1) == 1) begin
          special[9:0] = 10'($urandom_range(1, 1023));
        end else if ($urandom_range(2) == 0) begin
          special[14:10] = hf2u_pkg::EXP_ZERO;
        end
        return special;
      end
      8: return {1'b1, 15'($urandom)};
      default: return {1'b0, 5'($urandom_range(16, 30)), 10'($urandom)};
    endcase
  endfunction

  function automatic logic [63:0] random_pixel();
    return {random_half(), random_half(), random_half(), random_half()};
  endfunction

  // Offers one item, sometimes after a gap, and returns on the edge it is taken.
  task automatic send_pixel(input logic [63:0] pix);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tdata <= pix;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering and waits until every predicted item has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (waiting_pixels != 0);
  endtask

  task automatic set_depth(input logic [4:0] depth);
    drain_results();
    cfg_wr_data <= depth;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_corners();
    for (int i = 0; i < 6; i++) begin
      send_pixel({corner_halves[4*i+3], corner_halves[4*i+2],
                  corner_halves[4*i+1], corner_halves[4*i]});
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner values at the reset depth and at both ends of the depth range.
    send_corners();
    set_depth(5'd1);
    send_corners();
    set_depth(5'd16);
    send_corners();

    // Random phases, each with its own depth and idling pattern.
    for (int phase = 0; phase < 12; phase++) begin
      set_depth(phase < 10 ? phase_depths[phase] : 5'($urandom_range(0, 31)));
      send_idle_pct = 0;
      recv_stall_pct = 0;
      if (phase == 5) begin
        // Keep offering while the receiver holds off, so the block backs up.
        hold_req++;
        repeat (40) send_pixel(random_pixel());
      end
      case (phase % 4)
        1: send_idle_pct = 46;
        2: recv_stall_pct = 46;
        3: begin
          send_idle_pct = 19;
          recv_stall_pct = 19;
        end
        default: ;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 7 && n == PHASE_ITEMS / 2) begin
          drain_results();
        end
        send_pixel(random_pixel());
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("half_float_to_unorm_rgba test passed");
    end else begin
      $display("half_float_to_unorm_rgba test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/hf2u_pkg.sv
design/hf2u_chan.sv
design/hf2u_ctrl.sv
design/half_float_to_unorm_rgba.sv
tb/unorm_pixel_monitor.sv
tb/tb_half_float_to_unorm_rgba.sv
